// ----- hw/rtl/svpf_pkg.sv -----
// ----------------------------------------------------------------------------
// svpf_pkg
// Types and constants of the scan veiling point filter.
// ----------------------------------------------------------------------------
package svpf_pkg;

  localparam int RANGE_W     = 16;
  localparam int THR_W       = 17;
  localparam int COS_W       = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [THR_W-1:0]        THR_RESET = 17'd54395;
  localparam logic signed [COS_W-1:0] COS_RESET = 32'sd1073731624;
  localparam logic signed [COS_W-1:0] COS_ONE   = 32'sh4000_0000;

  // long arithmetic on 32-bit limbs
  localparam int LIMB_W    = 32;
  localparam int ASRC_W    = 4 * LIMB_W;
  localparam int BSRC_W    = 2 * LIMB_W;
  localparam int ACC_W     = 6 * LIMB_W;
  localparam int LI_W      = 2;
  localparam int LJ_W      = 1;
  localparam int OFF_W     = 3;
  localparam int CABS_W    = 31;
  localparam int SUM_SHIFT = 29;
  localparam int LHS_SHIFT = 90;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COS_THRESHOLD = 1'b0,
    REG_COS_INCREMENT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               range_valid;
    logic               scan_end;
  } in_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_out_mm;
    logic               out_valid;
    logic               dropped;
    logic               last_of_scan;
  } out_item_t;

  typedef struct packed {
    logic               emit_held;
    logic [RANGE_W-1:0] held_range;
    logic               held_valid;
    logic               judge;
    logic [RANGE_W-1:0] new_range;
    logic               new_valid;
    logic               last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH,
    ST_CALC,
    ST_COMPARE,
    ST_EMIT_HELD,
    ST_EMIT_LAST
  } back_state_t;

  typedef enum logic [2:0] {
    OP_R1SQ,
    OP_R2SQ,
    OP_PROD,
    OP_PC,
    OP_AB,
    OP_TSQ,
    OP_RHS,
    OP_DSQ
  } op_t;

endpackage

// ----- hw/rtl/svpf_fifo.sv -----
// ----------------------------------------------------------------------------
// svpf_fifo
// Small first-in first-out queue with show-ahead read.
// ----------------------------------------------------------------------------
module svpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/svpf_front.sv -----
// ----------------------------------------------------------------------------
// svpf_front
// Accepts samples, holds the previous one and forms pair commands.
// ----------------------------------------------------------------------------
module svpf_front #(
  parameter int RANGE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  svpf_pkg::in_item_t item,
  output logic               full,
  input  logic               cmd_full,
  output logic               cmd_push,
  output svpf_pkg::cmd_t     cmd
);

  import svpf_pkg::*;

  localparam int RW = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;

  logic [RW-1:0]      held_range;
  logic               held_valid;
  logic               have_held;
  logic               accept;
  logic [RANGE_W-1:0] new_range;

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign new_range = RANGE_W'(item.range_mm[RW-1:0]);

  // a request makes a command only when it has something to emit
  assign cmd_push = accept && (have_held || item.scan_end);

  always_comb begin
    cmd.emit_held  = have_held;
    cmd.held_range = RANGE_W'(held_range);
    cmd.held_valid = held_valid;
    cmd.judge      = have_held && held_valid && item.range_valid;
    cmd.new_range  = new_range;
    cmd.new_valid  = item.range_valid;
    cmd.last       = item.scan_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_range <= '0;
      held_valid <= 1'b0;
      have_held  <= 1'b0;
    end else if (accept) begin
      if (item.scan_end) begin
        held_range <= '0;
        held_valid <= 1'b0;
        have_held  <= 1'b0;
      end else begin
        held_range <= item.range_mm[RW-1:0];
        held_valid <= item.range_valid;
        have_held  <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/svpf_back.sv -----
// ----------------------------------------------------------------------------
// svpf_back
// Judges a sample pair on a shared 32x32 multiplier and emits results.
// ----------------------------------------------------------------------------
module svpf_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [svpf_pkg::THR_W-1:0]        thr,
  input  logic signed [svpf_pkg::COS_W-1:0] cos_inc,
  input  logic                              cmd_empty,
  input  svpf_pkg::cmd_t                    cmd_head,
  output logic                              cmd_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output svpf_pkg::out_item_t               res_data
);

  import svpf_pkg::*;

  back_state_t state;
  back_state_t state_next;
  op_t         op;
  op_t         op_next;
  cmd_t        cmd;

  logic [LI_W-1:0]      li;
  logic [LJ_W-1:0]      lj;
  logic [LI_W-1:0]      a_last;
  logic [LJ_W-1:0]      b_last;
  logic                 issue_last;
  logic [ASRC_W-1:0]    a_src;
  logic [BSRC_W-1:0]    b_src;
  logic [LIMB_W-1:0]    a_limb;
  logic [LIMB_W-1:0]    b_limb;
  logic [2*LIMB_W-1:0]  prod;
  logic [OFF_W-1:0]     prod_off;
  logic                 prod_vld;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_sum;

  logic [2*RANGE_W-1:0] r1sq;
  logic [2*RANGE_W-1:0] r2sq;
  logic [2*RANGE_W-1:0] prod_r;
  logic [63:0]          pc;
  logic [63:0]          a_val;
  logic [63:0]          b_val;
  logic [127:0]         ab;
  logic [63:0]          tsq;
  logic [ACC_W-1:0]     rhs;
  logic [63:0]          dsq;
  logic [2*RANGE_W-1:0] d;
  logic                 drop;

  logic signed [COS_W-1:0] cos_neg;
  logic [CABS_W-1:0]       cabs;
  logic [2*RANGE_W:0]      s;
  logic [63:0]             s_sh;
  logic [ACC_W-1:0]        lhs;

  // saturated magnitude of the beam increment cosine
  assign cos_neg = -cos_inc;
  always_comb begin
    if (cos_inc > COS_ONE || cos_inc < -COS_ONE) begin
      cabs = CABS_W'(COS_ONE);
    end else if (cos_inc < 0) begin
      cabs = cos_neg[CABS_W-1:0];
    end else begin
      cabs = cos_inc[CABS_W-1:0];
    end
  end

  // operand selection per operation
  always_comb begin
    unique case (op)
      OP_R1SQ: begin
        a_src = ASRC_W'(cmd.held_range);
        b_src = BSRC_W'(cmd.held_range);
        a_last = '0;
        b_last = '0;
      end
      OP_R2SQ: begin
        a_src = ASRC_W'(cmd.new_range);
        b_src = BSRC_W'(cmd.new_range);
        a_last = '0;
        b_last = '0;
      end
      OP_PROD: begin
        a_src = ASRC_W'(cmd.held_range);
        b_src = BSRC_W'(cmd.new_range);
        a_last = '0;
        b_last = '0;
      end
      OP_PC: begin
        a_src = ASRC_W'(prod_r);
        b_src = BSRC_W'(cabs);
        a_last = '0;
        b_last = '0;
      end
      OP_AB: begin
        a_src = ASRC_W'(a_val);
        b_src = b_val;
        a_last = LI_W'(1);
        b_last = LJ_W'(1);
      end
      OP_TSQ: begin
        a_src = ASRC_W'(thr);
        b_src = BSRC_W'(thr);
        a_last = '0;
        b_last = '0;
      end
      OP_RHS: begin
        a_src = ab;
        b_src = tsq;
        a_last = LI_W'(3);
        b_last = LJ_W'(1);
      end
      OP_DSQ: begin
        a_src = ASRC_W'(d);
        b_src = BSRC_W'(d);
        a_last = '0;
        b_last = '0;
      end
      default: begin
        a_src = '0;
        b_src = '0;
        a_last = '0;
        b_last = '0;
      end
    endcase
  end

  always_comb begin
    unique case (op)
      OP_R1SQ: op_next = OP_R2SQ;
      OP_R2SQ: op_next = OP_PROD;
      OP_PROD: op_next = OP_PC;
      OP_PC:   op_next = OP_AB;
      OP_AB:   op_next = OP_TSQ;
      OP_TSQ:  op_next = OP_RHS;
      OP_RHS:  op_next = OP_DSQ;
      OP_DSQ:  op_next = OP_R1SQ;
      default: op_next = OP_R1SQ;
    endcase
  end

  assign a_limb     = a_src[LIMB_W*li +: LIMB_W];
  assign b_limb     = b_src[LIMB_W*lj +: LIMB_W];
  assign issue_last = (li == a_last) && (lj == b_last);
  assign acc_sum    = prod_vld ? acc + (ACC_W'(prod) << (LIMB_W * prod_off)) : acc;

  assign s    = (2*RANGE_W+1)'(r1sq) + (2*RANGE_W+1)'(r2sq);
  assign s_sh = 64'(s) << SUM_SHIFT;
  assign lhs  = ACC_W'(dsq) << LHS_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd_head.judge) begin
            state_next = ST_ISSUE;
          end else if (cmd_head.emit_held) begin
            state_next = ST_EMIT_HELD;
          end else begin
            state_next = ST_EMIT_LAST;
          end
        end
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (op == OP_PC) begin
          state_next = ST_CALC;
        end else if (op == OP_DSQ) begin
          state_next = ST_COMPARE;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_CALC: begin
        state_next = ST_ISSUE;
      end
      ST_COMPARE: begin
        state_next = ST_EMIT_HELD;
      end
      ST_EMIT_HELD: begin
        res_data.range_out_mm = cmd.held_range;
        res_data.out_valid    = cmd.held_valid && !drop;
        res_data.dropped      = drop;
        res_data.last_of_scan = 1'b0;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = cmd.last ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        res_data.range_out_mm = cmd.new_range;
        res_data.out_valid    = cmd.new_valid;
        res_data.dropped      = 1'b0;
        res_data.last_of_scan = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // limb sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      li       <= '0;
      lj       <= '0;
      prod_vld <= 1'b0;
      op       <= OP_R1SQ;
    end else begin
      case (state)
        ST_IDLE: begin
          li       <= '0;
          lj       <= '0;
          prod_vld <= 1'b0;
          op       <= OP_R1SQ;
        end
        ST_ISSUE: begin
          prod_vld <= 1'b1;
          if (li == a_last) begin
            li <= '0;
            lj <= issue_last ? '0 : lj + 1'b1;
          end else begin
            li <= li + 1'b1;
          end
        end
        ST_FINISH: begin
          prod_vld <= 1'b0;
          li       <= '0;
          lj       <= '0;
          op       <= op_next;
        end
        default: begin
          prod_vld <= 1'b0;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod     <= a_limb * b_limb;
    prod_off <= OFF_W'(li) + OFF_W'(lj);
    case (state)
      ST_IDLE: begin
        acc <= '0;
        if (!cmd_empty) begin
          cmd  <= cmd_head;
          drop <= 1'b0;
        end
      end
      ST_ISSUE: begin
        acc <= acc_sum;
      end
      ST_FINISH: begin
        acc <= '0;
        case (op)
          OP_R1SQ: r1sq   <= acc_sum[2*RANGE_W-1:0];
          OP_R2SQ: r2sq   <= acc_sum[2*RANGE_W-1:0];
          OP_PROD: prod_r <= acc_sum[2*RANGE_W-1:0];
          OP_PC:   pc     <= acc_sum[63:0];
          OP_AB:   ab     <= acc_sum[127:0];
          OP_TSQ:  tsq    <= acc_sum[63:0];
          OP_RHS:  rhs    <= acc_sum;
          OP_DSQ:  dsq    <= acc_sum[63:0];
          default: ;
        endcase
      end
      ST_CALC: begin
        a_val <= s_sh - pc;
        b_val <= s_sh + pc;
        d     <= (r1sq >= r2sq) ? r1sq - r2sq : r2sq - r1sq;
      end
      ST_COMPARE: begin
        // zero norm never drops
        drop <= (a_val != '0) && (lhs > rhs);
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/scan_veiling_point_filter_top.sv -----
// ----------------------------------------------------------------------------
// scan_veiling_point_filter_top
// Marks veiling points of a lidar scan by judging neighbouring sample pairs.
// ----------------------------------------------------------------------------
// usage
//   input queue: a request (range, valid flag, end of scan) is taken when
//   push is high and full is low. results leave as a queue: the oldest is on
//   result while empty is low and is taken when pop is high.
//   each sample is emitted after its successor arrives; an end-of-scan sample
//   also flushes itself, so it gives up to two results.
//   a pair of two valid samples is judged on one shared 32x32 multiplier in
//   18 limb products; other commands skip the multiplier and only emit. the
//   sustained rate on streams of valid samples is set by that multiplier.
//   a two-entry command queue decouples intake from the judge, so input is
//   taken while the back end works; a two-entry result queue holds results
//   while pop is low, and the back end waits when it fills.
//   reset clears the held sample, both queues and the registers to their
//   defaults. the user must see that registers are written through cfg_write
//   only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module scan_veiling_point_filter_top #(
  parameter int RANGE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  svpf_pkg::in_item_t                  item,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output svpf_pkg::out_item_t                 result,
  input  logic                                cfg_write,
  input  logic [svpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [svpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import svpf_pkg::*;

  logic [THR_W-1:0]        cos_threshold_q16;
  logic signed [COS_W-1:0] cos_increment_q30;

  cmd_t      cmd_in;
  cmd_t      cmd_head;
  logic      cmd_push;
  logic      cmd_full;
  logic      cmd_pop;
  logic      cmd_empty;
  out_item_t res_in;
  logic      res_push;
  logic      res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_threshold_q16 <= THR_RESET;
      cos_increment_q30 <= COS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COS_THRESHOLD: cos_threshold_q16 <= cfg_data[THR_W-1:0];
        REG_COS_INCREMENT: cos_increment_q30 <= cfg_data;
        default: ;
      endcase
    end
  end

  svpf_front #(
    .RANGE_BITS(RANGE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  svpf_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  svpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .thr       (cos_threshold_q16),
    .cos_inc   (cos_increment_q30),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  svpf_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_drop_invalid: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.dropped) |-> !result.out_valid)
    else $error("dropped sample shown as valid");

  a_last_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last_of_scan) |-> !result.dropped)
    else $error("final sample of a scan dropped");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

endmodule

// ----- verif/scan_veiling_point_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the scan veiling point filter.
// Streams lidar scans into the block through its input queue and predicts
// every emitted sample with a wide-integer model of the pair test. Each
// popped result is compared field by field with the oldest predicted sample.
// Covers directed edge cases, register extremes, random scans under random
// gaps and output stalls, and a long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb;
  import svpf_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  in_item_t              item = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             result;
  logic                  cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // filter state mirrored by the predictor
  logic [THR_W-1:0]        thr_q16 = THR_RESET;
  logic signed [COS_W-1:0] inc_q30 = COS_RESET;
  logic [RANGE_W-1:0]      held_range = '0;
  logic                    held_valid = 1'b0;
  logic                    have_held = 1'b0;
  out_item_t               emitted_samples[$];

  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_max = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_start = 1'b0;

  int mismatch_count = 0;
  int requests_taken = 0;
  int samples_checked = 0;
  int drops_seen = 0;
  int full_stall_cycles = 0;
  int scans_sent = 0;
  int reg_writes = 0;

  scan_veiling_point_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // exact pair test: earlier sample near_r is dropped against far_r
  function automatic bit is_veiling(logic [RANGE_W-1:0] near_r, logic [RANGE_W-1:0] far_r);
    logic [255:0]            r1, r2, s, p, d, cabs, w, x, lhs, rhs, tt;
    logic signed [COS_W-1:0] c;
    logic [COS_W-1:0]        cmag;
    c = inc_q30;
    if (c > COS_ONE) c = COS_ONE;
    if (c < -COS_ONE) c = -COS_ONE;
    cmag = (c < 0) ? -c : c;
    cabs = 256'(cmag);
    r1 = 256'(near_r);
    r2 = 256'(far_r);
    s = r1 * r1 + r2 * r2;
    p = r1 * r2;
    d = (r2 * r2 >= r1 * r1) ? r2 * r2 - r1 * r1 : r1 * r1 - r2 * r2;
    w = (s * s) << 60;
    x = ((p * cabs) * (p * cabs)) << 2;
    w = w - x;
    if (w == '0) return 1'b0;
    lhs = (d * d) << 92;
    tt = 256'(thr_q16);
    rhs = tt * tt * w;
    return lhs > rhs;
  endfunction

  function automatic void filter_sample(in_item_t it);
    out_item_t o;
    logic      cut;
    if (have_held) begin
      cut = held_valid && it.range_valid && is_veiling(held_range, it.range_mm);
      o.range_out_mm = held_range;
      o.out_valid = held_valid && !cut;
      o.dropped = cut;
      o.last_of_scan = 1'b0;
      emitted_samples.push_back(o);
    end
    if (it.scan_end) begin
      o = '{range_out_mm: it.range_mm, out_valid: it.range_valid, dropped: 1'b0,
            last_of_scan: 1'b1};
      emitted_samples.push_back(o);
      have_held = 1'b0;
      held_range = '0;
      held_valid = 1'b0;
    end else begin
      have_held = 1'b1;
      held_range = it.range_mm;
      held_valid = it.range_valid;
    end
  endfunction

  // request monitor
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      requests_taken++;
      filter_sample(item);
    end
    if (!rst && push && full) full_stall_cycles++;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      samples_checked++;
      if (result.dropped === 1'b1) drops_seen++;
      if (emitted_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("sample %0d: emitted with nothing pending, range %0d valid %0b",
                   samples_checked, result.range_out_mm, result.out_valid);
      end else begin
        out_item_t want;
        want = emitted_samples.pop_front();
        if (result.range_out_mm !== want.range_out_mm || result.out_valid !== want.out_valid
            || result.dropped !== want.dropped || result.last_of_scan !== want.last_of_scan)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("sample %0d: want range %0d valid %0b dropped %0b last %0b,",
                     samples_checked, want.range_out_mm, want.out_valid, want.dropped,
                     want.last_of_scan,
                     " got range %0d valid %0b dropped %0b last %0b",
                     result.range_out_mm, result.out_valid,
                     result.dropped, result.last_of_scan);
        end
      end
    end
  end

  // output side: random stall runs, plus a long hold on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      stall_left = $urandom_range(0, stall_max);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_item_t mk(logic [RANGE_W-1:0] r, logic v, logic e);
    in_item_t it;
    it.range_mm = r;
    it.range_valid = v;
    it.scan_end = e;
    return it;
  endfunction

  function automatic logic [RANGE_W-1:0] next_range(logic [RANGE_W-1:0] prev);
    int v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom_range(0, 65535);
      2: v = $urandom_range(0, 1) * 65535;
      3: v = prev;
      4, 5: v = int'(prev) + int'($urandom_range(0, 64)) - 32;
      default: v = int'(prev) + int'($urandom_range(0, 4000)) - 2000;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[RANGE_W-1:0];
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
  endtask

  task automatic send_scan(int len);
    logic [RANGE_W-1:0] r;
    r = RANGE_W'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      r = next_range(r);
      send_item(mk(r, $urandom_range(0, 9) != 0, i == len - 1));
    end
    scans_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (emitted_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_COS_THRESHOLD) thr_q16 = data[THR_W-1:0];
    else inc_q30 = data;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_filter(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] inc);
    drain();
    write_reg(REG_COS_THRESHOLD, thr);
    write_reg(REG_COS_INCREMENT, inc);
  endtask

  task automatic test_single_and_pairs();
    gap_max = 2;
    stall_pct = 15;
    stall_max = 4;
    send_item(mk(16'd1000, 1'b1, 1'b1));
    send_item(mk(16'hFFFF, 1'b0, 1'b1));
    // zero norm pair
    send_item(mk(16'd0, 1'b1, 1'b0));
    send_item(mk(16'd0, 1'b1, 1'b1));
    // jump behind a near sample
    send_item(mk(16'd1000, 1'b1, 1'b0));
    send_item(mk(16'd3000, 1'b1, 1'b0));
    send_item(mk(16'd3010, 1'b1, 1'b1));
    // extremes, invalid in pair
    send_item(mk(16'hFFFF, 1'b1, 1'b0));
    send_item(mk(16'h0000, 1'b1, 1'b0));
    send_item(mk(16'h0000, 1'b0, 1'b1));
    send_item(mk(16'd5000, 1'b0, 1'b0));
    send_item(mk(16'd5000, 1'b1, 1'b0));
    send_item(mk(16'd9000, 1'b1, 1'b1));
    send_item(mk(16'd2000, 1'b1, 1'b0));
    send_item(mk(16'd2000, 1'b1, 1'b1));
    send_item(mk(16'd40000, 1'b1, 1'b0));
    send_item(mk(16'd12000, 1'b1, 1'b0));
    send_item(mk(16'd12005, 1'b1, 1'b0));
    send_item(mk(16'hAAAA, 1'b1, 1'b0));
    send_item(mk(16'h5555, 1'b1, 1'b1));
    // valid held sample closed by an invalid end of scan
    send_item(mk(16'd700, 1'b1, 1'b0));
    send_item(mk(16'd30000, 1'b0, 1'b1));
  endtask

  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] thr_pick [8] = '{32'd0, 32'd65536, 32'd131071, 32'd32768,
                                            32'd65535, 32'd54395, 32'd1, 32'd0};
    logic [CFG_DATA_W-1:0] inc_pick [8] = '{32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                            32'hC000_0000, 32'h3FFF_FFFF, 32'h0000_0000,
                                            32'h4000_0001, 32'h0};
    gap_max = 3;
    stall_pct = 10;
    stall_max = 6;
    thr_pick[7] = $urandom();
    inc_pick[7] = $urandom();
    for (int i = 0; i < 8; i++) begin
      set_filter(thr_pick[i], inc_pick[i]);
      send_item(mk(16'd777, 1'b1, 1'b0));
      send_item(mk(16'd777, 1'b1, 1'b0));
      send_item(mk(16'd0, 1'b1, 1'b0));
      send_item(mk(16'hFFFF, 1'b1, 1'b1));
      send_scan(12);
    end
  endtask

  task automatic test_random_scans();
    int                    sent;
    int                    len;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] inc;
    int                    gaps [5] = '{0, 4, 12, 0, 6};
    int                    stalls [5] = '{0, 20, 5, 40, 10};
    int                    stall_lens [5] = '{0, 8, 3, 3, 20};
    for (int phase = 0; phase < 5; phase++) begin
      thr = $urandom();
      thr[THR_W-1:0] = ($urandom_range(0, 3) == 0)
                       ? THR_W'($urandom_range(0, 131071))
                       : THR_W'($urandom_range(40000, 65536));
      case ($urandom_range(0, 3))
        0: inc = $urandom();
        1: inc = -(32'(COS_ONE) - 32'($urandom_range(0, 1 << 20)));
        default: inc = 32'(COS_ONE) - 32'($urandom_range(0, 1 << 20));
      endcase
      set_filter(thr, inc);
      gap_max = gaps[phase];
      stall_pct = stalls[phase];
      stall_max = stall_lens[phase];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
        send_scan(len);
        sent += len;
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_filter(CFG_DATA_W'(THR_RESET), CFG_DATA_W'(COS_RESET));
    gap_max = 0;
    stall_pct = 0;
    hold_start = 1'b1;
    for (int i = 0; i < 3; i++) send_scan(16);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_single_and_pairs();
    test_register_extremes();
    test_random_scans();
    test_output_backpressure();
    drain();
    mismatch_count += emitted_samples.size();
    $display("%0d requests in %0d scans, %0d samples checked, %0d of them dropped",
             requests_taken, scans_sent, samples_checked, drops_seen);
    $display("%0d register writes, input held off %0d cycles by a full block",
             reg_writes, full_stall_cycles);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d samples still pending", emitted_samples.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/svpf_pkg.sv
hw/rtl/svpf_fifo.sv
hw/rtl/svpf_front.sv
hw/rtl/svpf_back.sv
hw/rtl/scan_veiling_point_filter_top.sv
verif/scan_veiling_point_filter_tb.sv
